// ===== hw/rtl/urx_pkg.sv =====
// shared types and constants for the receive fifo with rts hysteresis
// no dependencies; used by urx_ctrl, uart_rx_fifo_rts_hysteresis and the testbench
package urx_pkg;

  // fifo geometry
  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FREE_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 8;
  localparam int LVL_W  = 9;

  // level register reset values, clamped to the register width
  localparam int LVL_MAX       = (1 << LVL_W) - 1;
  localparam int PAUSE_RST_I   = (DEPTH / 4 > LVL_MAX) ? LVL_MAX : DEPTH / 4;
  localparam int RESUME_RST_I  = (DEPTH / 2 > LVL_MAX) ? LVL_MAX : DEPTH / 2;
  localparam logic [LVL_W-1:0] PAUSE_RST  = LVL_W'(PAUSE_RST_I);
  localparam logic [LVL_W-1:0] RESUME_RST = LVL_W'(RESUME_RST_I);

  // opcodes
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RESUME = 1'b1;

  // input word
  typedef struct packed {
    logic              opcode;
    logic [DATA_W-1:0] rx_byte;
  } in_t;

  // result word
  typedef struct packed {
    logic [DATA_W-1:0] read_byte;
    logic              read_valid;
    logic              rts_level;
    logic              data_waiting;
    logic              overrun;
  } out_t;

  // memory request from control to the byte store
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

// ===== hw/rtl/uart_rx_fifo_rts_hysteresis.sv =====
// the result of a word is registered at the edge that accepts it
// throughput: one word per cycle while the receiver takes results; the result register refills whenever it is taken
// the byte store read port registers the oldest byte alongside the result flags
// reset (rst, synchronous, active high): fifo empty, rts clear, levels at depth/4
// and depth/2, no result pending; byte store contents are not cleared
module uart_rx_fifo_rts_hysteresis (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  urx_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output urx_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [urx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [urx_pkg::LVL_W-1:0]     cfg_data
);

  logic                       accept;
  urx_pkg::mem_req_t          mem_req;
  urx_pkg::out_t              result, result_q;
  logic [urx_pkg::DATA_W-1:0] rdata;

  // handshakes
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  urx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mem_req   (mem_req),
    .result    (result)
  );

  urx_ram #(
    .DATA_W (urx_pkg::DATA_W),
    .ADDR_W (urx_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_q <= result;
    end
  end

  // read byte comes straight from the store read register
  always_comb begin
    out_data           = result_q;
    out_data.read_byte = result_q.read_valid ? rdata : '0;
  end

endmodule

// ===== hw/rtl/urx_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module urx_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/urx_ctrl.sv =====
// fifo pointers, free space count, rts hysteresis and level registers
// depends on urx_pkg
module urx_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  urx_pkg::in_t                   in_data,
  input  logic                           cfg_we,
  input  logic [urx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [urx_pkg::LVL_W-1:0]      cfg_data,
  output urx_pkg::mem_req_t              mem_req,
  output urx_pkg::out_t                  result
);

  logic [urx_pkg::ADDR_W-1:0] write_index, write_index_next;
  logic [urx_pkg::ADDR_W-1:0] read_index, read_index_next;
  logic [urx_pkg::FREE_W-1:0] free_space, free_space_next;
  logic                       rts_paused, rts_paused_next;
  logic [urx_pkg::LVL_W-1:0]  pause_level, resume_level;
  logic                       is_rx, full, empty, do_write, do_read;

  localparam logic [urx_pkg::FREE_W-1:0] FREE_FULL = urx_pkg::FREE_W'(urx_pkg::DEPTH);
  localparam logic [urx_pkg::ADDR_W-1:0] LAST_IDX  = urx_pkg::ADDR_W'(urx_pkg::DEPTH - 1);
  // level compares run at the wider of the count and level widths
  localparam int CMP_W = (urx_pkg::FREE_W > urx_pkg::LVL_W) ? urx_pkg::FREE_W : urx_pkg::LVL_W;

  // decode the word against the current fill state
  always_comb begin
    is_rx    = (in_data.opcode == urx_pkg::OP_RX);
    full     = (free_space == '0);
    empty    = (free_space == FREE_FULL);
    do_write = is_rx && !full;
    do_read  = !is_rx && !empty;
  end

  // next pointers and free space
  always_comb begin
    write_index_next = write_index;
    read_index_next  = read_index;
    free_space_next  = free_space;
    if (do_write) begin
      write_index_next = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
      free_space_next  = free_space - 1'b1;
    end else if (do_read) begin
      read_index_next = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
      free_space_next = free_space + 1'b1;
    end
  end

  // rts hysteresis: pause checked on received bytes, resume on reads
  always_comb begin
    rts_paused_next = rts_paused;
    if (is_rx) begin
      if (!rts_paused && (CMP_W'(free_space_next) < CMP_W'(pause_level))) begin
        rts_paused_next = 1'b1;
      end
    end else begin
      if (rts_paused && (CMP_W'(free_space_next) > CMP_W'(resume_level))) begin
        rts_paused_next = 1'b0;
      end
    end
  end

  // byte store request and result flags
  always_comb begin
    mem_req.we           = accept && do_write;
    mem_req.waddr        = write_index;
    mem_req.wdata        = in_data.rx_byte;
    mem_req.re           = accept && do_read;
    mem_req.raddr        = read_index;
    result.read_byte     = '0;
    result.read_valid    = do_read;
    result.rts_level     = rts_paused_next;
    result.data_waiting  = (free_space_next != FREE_FULL);
    result.overrun       = is_rx && full;
  end

  // state update on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      read_index  <= '0;
      free_space  <= FREE_FULL;
      rts_paused  <= 1'b0;
    end else if (accept) begin
      write_index <= write_index_next;
      read_index  <= read_index_next;
      free_space  <= free_space_next;
      rts_paused  <= rts_paused_next;
    end
  end

  // level registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pause_level  <= urx_pkg::PAUSE_RST;
      resume_level <= urx_pkg::RESUME_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        urx_pkg::REG_PAUSE:  pause_level  <= cfg_data;
        urx_pkg::REG_RESUME: resume_level <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// testbench for uart_rx_fifo_rts_hysteresis: directed rows, then random fill/drain traffic,
// each result word checked against a fixed value or an in-bench fifo model; depends on urx_pkg and the dut
module tb;
  import urx_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 3;
  localparam int PHASES        = 8;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_e;

  // one row of the directed stimulus
  typedef struct {
    row_kind_e            kind;
    in_t                  word;
    bit                   fixed;
    out_t                 fixed_res;
    logic [CFG_IDX_W-1:0] idx;
    logic [LVL_W-1:0]     val;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LVL_W-1:0]     cfg_data;

  // fifo model state and level registers
  logic [DATA_W-1:0] fifo_mem [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [FREE_W-1:0] free_cnt;
  logic              rts_set;
  logic [LVL_W-1:0]  pause_lvl;
  logic [LVL_W-1:0]  resume_lvl;

  out_t due_results[$];
  row_t dir_rows[$];
  int   errors    = 0;
  int   cycles    = 0;
  int   gap_pct   = 0;
  int   stall_pct = 0;

  // per-phase traffic shape and level settings, extremes included
  traffic_e         phase_mix    [PHASES] = '{MIX_FILL, MIX_FILL, MIX_FILL, MIX_DRAIN,
                                              MIX_DRAIN, MIX_DRAIN, MIX_EVEN, MIX_EVEN};
  logic [LVL_W-1:0] phase_pause  [PHASES] = '{64, 200, 256, 0, 511, 32, 100, 150};
  logic [LVL_W-1:0] phase_resume [PHASES] = '{128, 30, 256, 511, 0, 224, 180, 60};
  int               idle_choice  [3]      = '{0, 10, 35};

  uart_rx_fifo_rts_hysteresis dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // fifo model: one word in, one result word out
  function automatic out_t fifo_step(in_t w);
    out_t r;
    r = '0;
    if (w.opcode == OP_RX) begin
      if (free_cnt == 0) begin
        r.overrun = 1'b1;
      end else begin
        fifo_mem[wr_ptr] = w.rx_byte;
        wr_ptr   = (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        free_cnt = free_cnt - 1'b1;
      end
      // pause check only on a received byte while rts is clear
      if (!rts_set && free_cnt < pause_lvl) rts_set = 1'b1;
    end else begin
      if (free_cnt < DEPTH) begin
        r.read_byte  = fifo_mem[rd_ptr];
        r.read_valid = 1'b1;
        rd_ptr   = (rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        free_cnt = free_cnt + 1'b1;
      end
      // resume check only on a read while rts is set
      if (rts_set && free_cnt > resume_lvl) rts_set = 1'b0;
    end
    r.rts_level    = rts_set;
    r.data_waiting = (free_cnt < DEPTH);
    return r;
  endfunction

  function automatic out_t res(logic [DATA_W-1:0] b, logic v, logic rts, logic pend,
                               logic ovr);
    out_t r;
    r.read_byte    = b;
    r.read_valid   = v;
    r.rts_level    = rts;
    r.data_waiting = pend;
    r.overrun      = ovr;
    return r;
  endfunction

  function automatic void add_word(logic op, logic [DATA_W-1:0] b, bit fixed, out_t r);
    row_t row;
    row.kind           = ROW_WORD;
    row.word.opcode    = op;
    row.word.rx_byte   = b;
    row.fixed          = fixed;
    row.fixed_res      = r;
    row.idx            = '0;
    row.val            = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] i, logic [LVL_W-1:0] v);
    row_t row;
    row.kind      = ROW_CFG;
    row.word      = '0;
    row.fixed     = 1'b0;
    row.fixed_res = '0;
    row.idx       = i;
    row.val       = v;
    dir_rows.push_back(row);
  endfunction

  // drive one word, predict its result once accepted
  task automatic send_word(in_t w, bit fixed, out_t fixed_res);
    out_t r;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    r = fifo_step(w);
    due_results.push_back(fixed ? fixed_res : r);
    @(negedge clk);
  endtask

  // random sender gap
  task automatic idle_gap();
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  // drain all outstanding results, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] i, logic [LVL_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= i;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (i == REG_PAUSE) pause_lvl = v;
    else if (i == REG_RESUME) resume_lvl = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver: random stall bursts
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 17);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (due_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_data.read_byte !== want.read_byte) begin
          $error("read_byte: expected %h, got %h", want.read_byte, out_data.read_byte);
          errors++;
        end
        if (out_data.read_valid !== want.read_valid) begin
          $error("read_valid: expected %b, got %b", want.read_valid, out_data.read_valid);
          errors++;
        end
        if (out_data.rts_level !== want.rts_level) begin
          $error("rts_level: expected %b, got %b", want.rts_level, out_data.rts_level);
          errors++;
        end
        if (out_data.data_waiting !== want.data_waiting) begin
          $error("data_waiting: expected %b, got %b", want.data_waiting,
                 out_data.data_waiting);
          errors++;
        end
        if (out_data.overrun !== want.overrun) begin
          $error("overrun: expected %b, got %b", want.overrun, out_data.overrun);
          errors++;
        end
      end
    end
  end

  // run limit
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    in_t              w;
    int               n;
    int               rx_pct;
    logic [LVL_W-1:0] p;
    logic [LVL_W-1:0] q;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    // model reset
    wr_ptr     = '0;
    rd_ptr     = '0;
    free_cnt   = FREE_W'(DEPTH);
    rts_set    = 1'b0;
    pause_lvl  = PAUSE_RST;
    resume_lvl = RESUME_RST;

    // directed rows: empty reads, byte extremes, level extremes and hysteresis
    add_word(OP_READ, 8'h00, 1'b1, res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    add_word(OP_RX,   8'h00, 1'b0, '0);
    add_word(OP_RX,   8'hFF, 1'b0, '0);
    add_word(OP_READ, 8'h00, 1'b1, res(8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
    add_word(OP_READ, 8'h00, 1'b1, res(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
    add_word(OP_READ, 8'h00, 1'b1, res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    add_cfg(REG_PAUSE, 9'd511);
    add_cfg(REG_RESUME, 9'd511);
    add_word(OP_RX,   8'h5A, 1'b1, res(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    add_word(OP_READ, 8'h00, 1'b1, res(8'h5A, 1'b1, 1'b1, 1'b0, 1'b0));
    // new resume level only acts on the next read
    add_cfg(REG_RESUME, 9'd0);
    add_word(OP_RX,   8'hA5, 1'b1, res(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    add_word(OP_READ, 8'h00, 1'b1, res(8'hA5, 1'b1, 1'b0, 1'b0, 1'b0));
    add_cfg(REG_PAUSE, 9'd0);
    add_word(OP_RX,   8'h3C, 1'b1, res(8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
    add_cfg(REG_PAUSE, 9'd256);
    add_cfg(REG_RESUME, 9'd256);
    add_word(OP_RX,   8'hC3, 1'b1, res(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
    add_word(OP_READ, 8'h00, 1'b1, res(8'h3C, 1'b1, 1'b1, 1'b1, 1'b0));
    add_word(OP_READ, 8'h00, 1'b1, res(8'hC3, 1'b1, 1'b1, 1'b0, 1'b0));
    add_word(OP_READ, 8'h00, 1'b1, res(8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
    // resume check still made on an empty read
    add_cfg(REG_RESUME, 9'd255);
    add_word(OP_READ, 8'h00, 1'b1, res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    add_word(OP_RX,   8'h81, 1'b0, '0);
    add_word(OP_RX,   8'h7E, 1'b0, '0);
    add_word(OP_READ, 8'h00, 1'b0, '0);
    add_word(OP_READ, 8'h00, 1'b0, '0);

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    gap_pct   = 20;
    stall_pct = 20;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].fixed_res);
        idle_gap();
      end
    end

    // random phases: fill to overrun, drain to empty, then mixed traffic
    for (int ph = 0; ph < PHASES; ph++) begin
      p = (ph >= 6) ? LVL_W'($urandom_range(0, 511)) : phase_pause[ph];
      q = (ph >= 6) ? LVL_W'($urandom_range(0, 511)) : phase_resume[ph];
      settle();
      write_reg(REG_PAUSE, p);
      settle();
      write_reg(REG_RESUME, q);
      if (ph == PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = idle_choice[$urandom_range(0, 2)];
        stall_pct = idle_choice[$urandom_range(0, 2)];
      end
      case (phase_mix[ph])
        MIX_FILL:  rx_pct = 95;
        MIX_DRAIN: rx_pct = 5;
        default:   rx_pct = 50;
      endcase
      n = $urandom_range(100, 136);
      repeat (n) begin
        w.opcode  = ($urandom_range(0, 99) < rx_pct) ? OP_RX : OP_READ;
        w.rx_byte = DATA_W'($urandom_range(0, 255));
        send_word(w, 1'b0, '0);
        idle_gap();
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
